// ----- design/tun_pkg.sv -----
`default_nettype none
package tun_pkg;
   localparam int COORD_W = 12;
   localparam int EDGE_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * EDGE_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int SQ_W    = 2 * (CROSS_W - 1);
   localparam int LEN_W   = SQ_W + 2;
   localparam int FRAC    = 14;
   localparam int M_W     = FRAC + 1;
   localparam int ACC_W   = LEN_W + 2 * FRAC + 4;
   localparam int OUT_W   = 16;
   localparam int N_CELLS = M_W;
   localparam int FRONT_STAGES = 5;

   // one lane per normal component; t is the squared length at the cell's bit weight
   typedef struct packed {
      logic [2:0][ACC_W-1:0] rem;
      logic [2:0][ACC_W-1:0] yk;
      logic [2:0][M_W-1:0]   m;
      logic [ACC_W-1:0]      t;
      logic [2:0]            neg;
      logic                  degen;
   } cell_data_type;
endpackage
`default_nettype wire

// ----- design/triangle_unit_normal_unit.sv -----
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_p{0,1,2}_{x,y,z}, 12b signed each
// rsp       out        rsp_valid/rsp_stall   rsp_norm_{x,y,z} 16b Q1.14, rsp_degenerate
//
// One transaction per cycle sustained while rsp is not stalled; 5 front stages, 15 cells,
// one output register.
// Each cell settles one bit of the three normal magnitudes, MSB first.
// Stages advance independently: a bubble is squeezed out even while rsp is stalled.
// Synchronous reset clears only valid bits; payload registers are not reset.
`default_nettype none
module triangle_unit_normal_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [tun_pkg::COORD_W-1:0] req_p0_x,
   input  wire logic signed [tun_pkg::COORD_W-1:0] req_p0_y,
   input  wire logic signed [tun_pkg::COORD_W-1:0] req_p0_z,
   input  wire logic signed [tun_pkg::COORD_W-1:0] req_p1_x,
   input  wire logic signed [tun_pkg::COORD_W-1:0] req_p1_y,
   input  wire logic signed [tun_pkg::COORD_W-1:0] req_p1_z,
   input  wire logic signed [tun_pkg::COORD_W-1:0] req_p2_x,
   input  wire logic signed [tun_pkg::COORD_W-1:0] req_p2_y,
   input  wire logic signed [tun_pkg::COORD_W-1:0] req_p2_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [tun_pkg::OUT_W-1:0]   rsp_norm_x,
   output logic signed [tun_pkg::OUT_W-1:0]   rsp_norm_y,
   output logic signed [tun_pkg::OUT_W-1:0]   rsp_norm_z,
   output logic                               rsp_degenerate
);
   import tun_pkg::*;

   logic [8:0][COORD_W-1:0] p;
   logic                    front_in_move;

   // cell chain: index 0 is the front-end output, N_CELLS the last cell
   logic          cell_valid [N_CELLS+1];
   logic          cell_move  [N_CELLS+1];
   cell_data_type cell_data  [N_CELLS+1];

   logic                         rsp_move;
   logic                         rsp_valid_ff;
   logic [2:0][OUT_W-1:0]        norm_ff;
   logic                         degen_ff;
   logic [2:0][OUT_W-1:0]        norm_in;

   assign p = {req_p2_z, req_p2_y, req_p2_x,
               req_p1_z, req_p1_y, req_p1_x,
               req_p0_z, req_p0_y, req_p0_x};

   assign req_stall = !front_in_move;

   // edges, cross product, squares, squared length
   tun_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_move   (front_in_move),
      .in_p      (p),
      .out_valid (cell_valid[0]),
      .out_move  (cell_move[0]),
      .out_data  (cell_data[0])
   );

   // restoring square-root-free search: cell k decides magnitude bit FRAC-k
   for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
      tun_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[g]),
         .in_move   (cell_move[g]),
         .in_data   (cell_data[g]),
         .out_valid (cell_valid[g+1]),
         .out_move  (cell_move[g+1]),
         .out_data  (cell_data[g+1])
      );
   end

   assign rsp_move             = !rsp_valid_ff || !rsp_stall;
   assign cell_move[N_CELLS]   = rsp_move;

   // apply sign; degenerate triangles force zero
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (cell_data[N_CELLS].degen) begin
            norm_in[i] = '0;
         end else if (cell_data[N_CELLS].neg[i]) begin
            norm_in[i] = OUT_W'(0) - OUT_W'(cell_data[N_CELLS].m[i]);
         end else begin
            norm_in[i] = OUT_W'(cell_data[N_CELLS].m[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_move) begin
         rsp_valid_ff <= cell_valid[N_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_move) begin
         norm_ff  <= norm_in;
         degen_ff <= cell_data[N_CELLS].degen;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_norm_x     = norm_ff[0];
   assign rsp_norm_y     = norm_ff[1];
   assign rsp_norm_z     = norm_ff[2];
   assign rsp_degenerate = degen_ff;
endmodule
`default_nettype wire

// ----- design/tun_front.sv -----
`default_nettype none
module tun_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   output logic                                 in_move,
   input  wire logic [8:0][tun_pkg::COORD_W-1:0] in_p,
   output logic                                 out_valid,
   input  wire logic                            out_move,
   output tun_pkg::cell_data_type               out_data
);
   import tun_pkg::*;

   logic [FRONT_STAGES:1] v_ff;
   logic [FRONT_STAGES+1:1] mv;

   logic signed [2:0][EDGE_W-1:0]  a_ff, b_ff;
   logic signed [5:0][PROD_W-1:0]  p_ff;
   logic signed [2:0][CROSS_W-1:0] c_ff;
   logic [2:0][SQ_W-1:0]           sq_ff;
   logic [2:0]                     neg_ff;
   cell_data_type                  out_ff;

   logic signed [EDGE_W-1:0]    ea [3];
   logic signed [EDGE_W-1:0]    eb [3];
   logic signed [2*CROSS_W-1:0] sq_full [3];
   logic [LEN_W-1:0]            len_in;

   always_comb begin
      mv[FRONT_STAGES+1] = out_move;
      for (int k = FRONT_STAGES; k >= 1; k--) begin
         mv[k] = !v_ff[k] || mv[k+1];
      end
   end
   assign in_move   = mv[1];
   assign out_valid = v_ff[FRONT_STAGES];
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (mv[1]) begin
            v_ff[1] <= in_valid;
         end
         for (int k = 2; k <= FRONT_STAGES; k++) begin
            if (mv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // packed-array elements are unsigned; products need explicit $signed
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ea[i] = $signed({in_p[i][COORD_W-1], in_p[i]})
               - $signed({in_p[i+3][COORD_W-1], in_p[i+3]});
         eb[i] = $signed({in_p[i+3][COORD_W-1], in_p[i+3]})
               - $signed({in_p[i+6][COORD_W-1], in_p[i+6]});
         sq_full[i] = $signed(c_ff[i]) * $signed(c_ff[i]);
      end
      len_in = LEN_W'(sq_ff[0]) + LEN_W'(sq_ff[1]) + LEN_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (mv[1]) begin
         for (int i = 0; i < 3; i++) begin
            a_ff[i] <= ea[i];
            b_ff[i] <= eb[i];
         end
      end
      if (mv[2]) begin
         p_ff[0] <= PROD_W'($signed(a_ff[1]) * $signed(b_ff[2]));
         p_ff[1] <= PROD_W'($signed(a_ff[2]) * $signed(b_ff[1]));
         p_ff[2] <= PROD_W'($signed(a_ff[2]) * $signed(b_ff[0]));
         p_ff[3] <= PROD_W'($signed(a_ff[0]) * $signed(b_ff[2]));
         p_ff[4] <= PROD_W'($signed(a_ff[0]) * $signed(b_ff[1]));
         p_ff[5] <= PROD_W'($signed(a_ff[1]) * $signed(b_ff[0]));
      end
      if (mv[3]) begin
         for (int i = 0; i < 3; i++) begin
            c_ff[i] <= $signed({p_ff[2*i][PROD_W-1], p_ff[2*i]})
                     - $signed({p_ff[2*i+1][PROD_W-1], p_ff[2*i+1]});
         end
      end
      if (mv[4]) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i]  <= sq_full[i][SQ_W-1:0];
            neg_ff[i] <= c_ff[i][CROSS_W-1];
         end
      end
      if (mv[5]) begin
         for (int i = 0; i < 3; i++) begin
            out_ff.rem[i] <= {{(ACC_W-SQ_W-2*FRAC){1'b0}}, sq_ff[i], {(2*FRAC){1'b0}}};
            out_ff.yk[i]  <= '0;
            out_ff.m[i]   <= '0;
         end
         out_ff.t     <= {{(ACC_W-LEN_W-2*FRAC){1'b0}}, len_in, {(2*FRAC){1'b0}}};
         out_ff.neg   <= neg_ff;
         out_ff.degen <= (len_in == '0);
      end
   end
endmodule
`default_nettype wire

// ----- design/tun_cell.sv -----
`default_nettype none
module tun_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_move,
   input  wire tun_pkg::cell_data_type in_data,
   output logic                        out_valid,
   input  wire logic                   out_move,
   output tun_pkg::cell_data_type      out_data
);
   import tun_pkg::*;

   logic          valid_ff;
   cell_data_type data_ff;
   cell_data_type data_in;

   logic [ACC_W-1:0] d [3];
   logic [2:0]       take;

   // trial bit: accept when remainder covers 2*m*S*w + S*w^2 (both pre-scaled)
   always_comb begin
      data_in = in_data;
      for (int i = 0; i < 3; i++) begin
         d[i]    = in_data.yk[i] + in_data.t;
         take[i] = in_data.rem[i] >= d[i];
         data_in.rem[i] = take[i] ? in_data.rem[i] - d[i] : in_data.rem[i];
         data_in.yk[i]  = (take[i] ? in_data.yk[i] + {in_data.t[ACC_W-2:0], 1'b0}
                                   : in_data.yk[i]) >> 1;
         data_in.m[i]   = {in_data.m[i][M_W-2:0], take[i]};
      end
      data_in.t = in_data.t >> 2;
   end

   assign in_move   = !valid_ff || out_move;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_move) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move) begin
         data_ff <= data_in;
      end
   end
endmodule
`default_nettype wire

// ----- design/tun_checker.sv -----
`default_nettype none
module tun_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic signed [tun_pkg::OUT_W-1:0]    rsp_norm_x,
   input wire logic signed [tun_pkg::OUT_W-1:0]    rsp_norm_y,
   input wire logic signed [tun_pkg::OUT_W-1:0]    rsp_norm_z,
   input wire logic                                rsp_degenerate
);
   import tun_pkg::*;

   localparam logic signed [OUT_W-1:0] ONE  = OUT_W'(1 << FRAC);
   localparam logic signed [OUT_W-1:0] MONE = -ONE;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp transaction dropped while stalled");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_norm_x == '0 && rsp_norm_y == '0 && rsp_norm_z == '0)
      else $error("degenerate result not zero");

   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_norm_x != '0 || rsp_norm_y != '0 || rsp_norm_z != '0)
      else $error("nondegenerate normal is zero");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_norm_x <= ONE && rsp_norm_x >= MONE &&
         rsp_norm_y <= ONE && rsp_norm_y >= MONE &&
         rsp_norm_z <= ONE && rsp_norm_z >= MONE)
      else $error("normal component out of unit range");
endmodule

bind triangle_unit_normal_unit tun_checker u_tun_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_norm_x     (rsp_norm_x),
   .rsp_norm_y     (rsp_norm_y),
   .rsp_norm_z     (rsp_norm_z),
   .rsp_degenerate (rsp_degenerate)
);
`default_nettype wire

// ----- bench/tb_triangle_unit_normal_unit.sv -----
`default_nettype none
module tb_triangle_unit_normal_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import tun_pkg::*;

   localparam int LATENCY   = 21;
   localparam int WATCH_MAX = 5000;
   localparam int N_RANDOM  = 800;

   typedef logic signed [COORD_W-1:0] coord_t;
   typedef logic signed [OUT_W-1:0]   norm_t;

   typedef struct {
      coord_t p[9];
   } tri_t;

   typedef struct {
      norm_t nx, ny, nz;
      logic  degen;
   } normal_t;

   // Predicts the unit normal of each accepted triangle and checks each result
   // against the oldest prediction.
   class normal_scoreboard;
      normal_t pending[$];
      int      mismatches;

      // largest m in 0..2^FRAC with m*m*len2 <= mag*mag*2^(2*FRAC)
      function automatic longint unsigned unit_mag(longint unsigned mag,
                                                    logic [127:0] len2);
         logic [127:0] goal, prod;
         longint unsigned lo, hi, mid;
         goal = ({64'd0, mag} * {64'd0, mag}) << (2 * FRAC);
         lo = 0;
         hi = 64'd1 << FRAC;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            prod = {64'd0, mid * mid} * len2;
            if (prod <= goal) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      endfunction

      function void note_triangle(tri_t t);
         longint ax, ay, az, bx, by, bz;
         longint c[3];
         longint unsigned mag;
         logic [127:0] len2;
         normal_t r;
         norm_t comp[3];
         ax = t.p[0] - t.p[3]; ay = t.p[1] - t.p[4]; az = t.p[2] - t.p[5];
         bx = t.p[3] - t.p[6]; by = t.p[4] - t.p[7]; bz = t.p[5] - t.p[8];
         c[0] = ay * bz - az * by;
         c[1] = az * bx - ax * bz;
         c[2] = ax * by - ay * bx;
         if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
            r = '{0, 0, 0, 1'b1};
         end else begin
            len2 = 0;
            for (int i = 0; i < 3; i++) begin
               mag = c[i] < 0 ? -c[i] : c[i];
               len2 += {64'd0, mag} * {64'd0, mag};
            end
            for (int i = 0; i < 3; i++) begin
               mag = unit_mag(c[i] < 0 ? -c[i] : c[i], len2);
               comp[i] = c[i] < 0 ? norm_t'(-mag) : norm_t'(mag);
            end
            r = '{comp[0], comp[1], comp[2], 1'b0};
         end
         pending.push_back(r);
      endfunction

      function void check_normal(normal_t got);
         normal_t want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         want = pending.pop_front();
         if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
             got.degen !== want.degen) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %0d %0d %0d d%0b, got %0d %0d %0d d%0b",
                        want.nx, want.ny, want.nz, want.degen,
                        got.nx, got.ny, got.nz, got.degen);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   coord_t req_p[9];
   logic rsp_valid;
   logic rsp_stall = 1;
   norm_t rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic rsp_degenerate;

   // pacing controls: percent idle for each side, and the long hold-off flag
   int  send_idle = 32;
   int  recv_idle = 69;
   bit  hold_off  = 0;
   bit  sending   = 1;
   int  quiet     = 0;
   int  accepted  = 0;

   normal_scoreboard board = new();

   always #6 clock = ~clock;

   initial foreach (req_p[i]) req_p[i] = '0;

   triangle_unit_normal_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_p0_x(req_p[0]), .req_p0_y(req_p[1]), .req_p0_z(req_p[2]),
      .req_p1_x(req_p[3]), .req_p1_y(req_p[4]), .req_p1_z(req_p[5]),
      .req_p2_x(req_p[6]), .req_p2_y(req_p[7]), .req_p2_z(req_p[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_norm_x(rsp_norm_x), .rsp_norm_y(rsp_norm_y), .rsp_norm_z(rsp_norm_z),
      .rsp_degenerate(rsp_degenerate)
   );

   // sample both channels at the rising edge; watchdog counts idle cycles
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tri_t t;
            foreach (t.p[i]) t.p[i] = req_p[i];
            board.note_triangle(t);
            accepted++;
         end
         if (rsp_valid && !rsp_stall)
            board.check_normal('{rsp_norm_x, rsp_norm_y, rsp_norm_z, rsp_degenerate});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
         else quiet <= quiet + 1;
         if (quiet >= WATCH_MAX) begin
            $display("FAIL triangle_unit_normal_unit");
            $finish;
         end
      end
   end

   // receiver: random stall at the falling edge, forced high during hold-off
   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   // offer one triangle, keeping it stable until the transaction completes
   task automatic send_triangle(tri_t t);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      foreach (t.p[i]) req_p[i] <= t.p[i];
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic tri_t random_triangle();
      tri_t t;
      int kind;
      kind = $urandom_range(9);
      foreach (t.p[i]) begin
         case (kind)
            0: t.p[i] = $urandom_range(1) ? 12'sh7ff : 12'sh800;  // extremes
            1: t.p[i] = coord_t'($urandom_range(7) - 4);          // tiny triangles
            default: t.p[i] = coord_t'($urandom);
         endcase
      end
      // collinear or coincident vertices now and then
      if (kind == 2) foreach (t.p[i]) if (i >= 6) t.p[i] = t.p[i - 3];
      if (kind == 3)
         for (int i = 0; i < 3; i++) t.p[6 + i] = 2 * t.p[3 + i] - t.p[i];
      return t;
   endfunction

   function automatic tri_t make_tri(int a0, a1, a2, b0, b1, b2, c0, c1, c2);
      tri_t t;
      t.p = '{coord_t'(a0), coord_t'(a1), coord_t'(a2), coord_t'(b0), coord_t'(b1),
              coord_t'(b2), coord_t'(c0), coord_t'(c1), coord_t'(c2)};
      return t;
   endfunction

   initial begin
      tri_t dir[$];
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: axis-aligned normals, degenerate cases, coordinate extremes
      dir.push_back(make_tri(0, 0, 0, 1, 0, 0, 1, 1, 0));
      dir.push_back(make_tri(0, 0, 0, 0, 1, 0, 0, 1, 1));
      dir.push_back(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 1));
      dir.push_back(make_tri(0, 0, 0, 1, 1, 0, 1, 0, 0));
      dir.push_back(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5));
      dir.push_back(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
      dir.push_back(make_tri(-2048, -2048, -2048, 2047, 2047, 2047, -2048, -2048, -2048));
      dir.push_back(make_tri(2047, -2048, 0, -2048, 2047, 0, 2047, 2047, -2048));
      dir.push_back(make_tri(-2048, 2047, -2048, 2047, -2048, 2047, -2048, -2048, 2047));
      dir.push_back(make_tri(-2048, 0, 0, 2047, 0, 0, 2047, 2047, 0));
      dir.push_back(make_tri(0, -2048, 2047, 0, 2047, -2048, 2047, 0, 0));
      dir.push_back(make_tri(2047, 2047, 2047, -2048, 2047, 2047, 2047, -2048, -2048));
      dir.push_back(make_tri(0, 0, 0, 3, 4, 0, 0, 0, 5));
      dir.push_back(make_tri(1, 2, 3, -3, 7, 1, 4, -5, 9));
      dir.push_back(make_tri(-1, -1, -1, 0, 0, 0, -1, 0, 1));
      dir.push_back(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1));
      foreach (dir[i]) send_triangle(dir[i]);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 3) begin
            send_idle = 69; recv_idle = 32;
         end
         if (n == 2 * N_RANDOM / 3) begin
            send_idle = 0; recv_idle = 0;
         end
         // long receiver hold-off while the sender keeps offering; fills the pipe
         if (n == N_RANDOM / 2) hold_off = 1;
         send_triangle(random_triangle());
      end
      req_valid <= 1'b0;
      sending = 0;
   end

   // counts the hold-off in cycles in its own process
   initial begin
      wait (hold_off);
      repeat (200) @(posedge clock);
      hold_off = 0;
   end

   initial begin
      wait (!reset);
      wait (!sending);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("PASS triangle_unit_normal_unit");
      else
         $display("FAIL triangle_unit_normal_unit");
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
design/tun_pkg.sv
design/tun_front.sv
design/tun_cell.sv
design/triangle_unit_normal_unit.sv
design/tun_checker.sv
bench/tb_triangle_unit_normal_unit.sv
